### design/ptss_pkg.sv
// ----------------------------------------------------------------------------
// ptss_pkg - shared types and codes for the periodic task slot scheduler
// Input and result payload structs, item kinds, result status codes and
// the fixed constants of the slot table.
// ----------------------------------------------------------------------------
package ptss_pkg;

	// Item kinds
	localparam logic [1:0] KIND_SCHED   = 2'd0;
	localparam logic [1:0] KIND_UNSCHED = 2'd1;
	localparam logic [1:0] KIND_TICK    = 2'd2;

	// Result status codes
	localparam logic [1:0] STAT_SCHEDULED = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_ON_TIME   = 2'd2;
	localparam logic [1:0] STAT_LATE      = 2'd3;

	// Period value that marks a one-shot task
	localparam logic [31:0] ONE_SHOT = 32'hFFFF_FFFF;

	// Late tolerance after reset
	localparam logic [15:0] TOL_RESET = 16'd10;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  slot;
		logic [31:0] period;
		logic [31:0] first_due;
		logic [31:0] now;
	} in_item_t;

	typedef struct packed {
		logic [4:0] slot_index;
		logic [1:0] status;
		logic       last;
	} out_item_t;

endpackage

### design/periodic_task_slot_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler - bitmap slot table of periodic timers
// Schedules tasks into the lowest free slot, frees slots on request and, on
// each tick, walks the table and reports every due slot, re-arming periodic
// tasks and freeing one-shot tasks.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                       Direction  Moves
//  -------  ----------------------------  ---------  ---------------------------
//  in       in_valid, in_ready, in_data   input      schedule / unschedule / tick
//  out      out_valid, out_ready, out_data output    slot result, last flags end
//  cfg      cfg_we, cfg_wdata             input      late tolerance register
//
//  A tick keeps in_ready low for the whole walk: the slot table is read one
//  slot per cycle through a registered read port unless the walk stalls, then
//  the last slot is evaluated, the walk is closed and the final result is
//  released. A schedule tests one occupancy bit per cycle, lowest first.
//  An unschedule completes in the accept cycle; in_ready stays high.
//  A due result is held one result back so its last flag is known; a full output
//  register stalls the walk. Reset clears the occupancy map and restores the
//  tolerance to its reset value.
//
module periodic_task_slot_scheduler #(
	parameter int SLOTS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ptss_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ptss_pkg::out_item_t  out_data,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_wdata
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCHED,
		S_TICK,
		S_FLUSH
	} state_t;

	state_t               state_q;
	logic [SLOTS-1:0]     occ_q;
	logic [15:0]          tol_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [31:0]          period_q;
	logic [31:0]          first_due_q;
	logic [31:0]          now_q;
	logic                 out_valid_q;
	ptss_pkg::out_item_t  out_q;
	logic                 pend_valid_q;
	ptss_pkg::out_item_t  pend_q;

	// Evaluation stage behind the table read
	logic                 ev_valid_s1;
	logic [IDX_W-1:0]     ev_idx_s1;
	logic [31:0]          due_s1;
	logic [31:0]          per_s1;

	// Slot table storage
	logic [31:0]          due_mem [SLOTS];
	logic [31:0]          per_mem [SLOTS];

	logic                 out_free;
	logic [IDX_W-1:0]     cnt_idx;
	logic                 cnt_end;
	logic                 sched_free;
	logic                 hit;
	logic [32:0]          late_sum;
	logic                 late;
	logic [31:0]          rearm;
	logic                 one_shot;
	logic                 stall;
	logic                 walk_done;
	logic                 rd_en;
	logic                 due_we;
	logic                 per_we;
	logic [IDX_W-1:0]     wr_addr;
	logic [31:0]          due_wdata;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Output register can take a new result this cycle
	assign out_free = !out_valid_q || out_ready;

	// Walk counter decode
	assign cnt_idx    = cnt_q[IDX_W-1:0];
	assign cnt_end    = (cnt_q == CNT_W'(SLOTS));
	assign sched_free = !occ_q[cnt_idx];

	// Shared evaluation unit: due test, late test, re-arm add
	assign late_sum  = {1'b0, due_s1} + {17'd0, tol_q};
	assign late      = ({1'b0, now_q} >= late_sum);
	assign rearm     = now_q + per_s1;
	assign one_shot  = (per_s1 == ptss_pkg::ONE_SHOT);
	assign hit       = ev_valid_s1 && occ_q[ev_idx_s1] && (now_q >= due_s1);
	assign stall     = hit && pend_valid_q && !out_free;
	assign walk_done = cnt_end && !ev_valid_s1;
	assign rd_en     = (state_q == S_TICK) && !stall && !cnt_end;

	// Table write port select
	always_comb begin
		due_we    = 1'b0;
		per_we    = 1'b0;
		wr_addr   = cnt_idx;
		due_wdata = first_due_q;
		if (state_q == S_SCHED && !cnt_end && sched_free && out_free) begin
			due_we = 1'b1;
			per_we = 1'b1;
		end else if (state_q == S_TICK && hit && !stall && !one_shot) begin
			due_we    = 1'b1;
			wr_addr   = ev_idx_s1;
			due_wdata = rearm;
		end
	end

	// Slot table: one write port, registered read
	always_ff @(posedge clk) begin
		if (due_we) begin
			due_mem[wr_addr] <= due_wdata;
		end
		if (per_we) begin
			per_mem[wr_addr] <= period_q;
		end
		if (rd_en) begin
			due_s1 <= due_mem[cnt_idx];
			per_s1 <= per_mem[cnt_idx];
		end
	end

	// Sequencer, occupancy map and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			occ_q        <= '0;
			tol_q        <= ptss_pkg::TOL_RESET;
			cnt_q        <= '0;
			period_q     <= '0;
			first_due_q  <= '0;
			now_q        <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
			pend_valid_q <= 1'b0;
			pend_q       <= '0;
			ev_valid_s1  <= 1'b0;
			ev_idx_s1    <= '0;
		end else begin
			// Drop the output once it is transferred
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				tol_q <= cfg_wdata;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						unique case (in_data.kind)
							ptss_pkg::KIND_SCHED: begin
								period_q    <= in_data.period;
								first_due_q <= in_data.first_due;
								cnt_q       <= '0;
								state_q     <= S_SCHED;
							end
							ptss_pkg::KIND_UNSCHED: begin
								if (in_data.slot < 6'(SLOTS)) begin
									occ_q[in_data.slot[IDX_W-1:0]] <= 1'b0;
								end
							end
							ptss_pkg::KIND_TICK: begin
								now_q       <= in_data.now;
								cnt_q       <= '0;
								ev_valid_s1 <= 1'b0;
								state_q     <= S_TICK;
							end
							default: begin
							end
						endcase
					end
				end

				S_SCHED: begin
					// Test one occupancy bit per cycle, lowest first
					priority if (cnt_end) begin
						if (out_free) begin
							out_valid_q      <= 1'b1;
							out_q.slot_index <= '0;
							out_q.status     <= ptss_pkg::STAT_FULL;
							out_q.last       <= 1'b1;
							state_q          <= S_IDLE;
						end
					end else if (sched_free) begin
						if (out_free) begin
							occ_q[cnt_idx]   <= 1'b1;
							out_valid_q      <= 1'b1;
							out_q.slot_index <= 5'(cnt_idx);
							out_q.status     <= ptss_pkg::STAT_SCHEDULED;
							out_q.last       <= 1'b1;
							state_q          <= S_IDLE;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end

				S_TICK: begin
					if (!stall) begin
						// Advance the read side
						if (!cnt_end) begin
							ev_valid_s1 <= 1'b1;
							ev_idx_s1   <= cnt_idx;
							cnt_q       <= cnt_q + 1'b1;
						end else begin
							ev_valid_s1 <= 1'b0;
						end
						// Retire the held result, hold the new one
						if (hit) begin
							if (pend_valid_q) begin
								out_valid_q <= 1'b1;
								out_q       <= pend_q;
							end
							pend_valid_q      <= 1'b1;
							pend_q.slot_index <= 5'(ev_idx_s1);
							pend_q.status     <= late ? ptss_pkg::STAT_LATE
							                          : ptss_pkg::STAT_ON_TIME;
							pend_q.last       <= 1'b0;
							if (one_shot) begin
								occ_q[ev_idx_s1] <= 1'b0;
							end
						end
						if (walk_done) begin
							state_q <= S_FLUSH;
						end
					end
				end

				S_FLUSH: begin
					// Release the final result with last set
					if (!pend_valid_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_valid_q      <= 1'b1;
						out_q.slot_index <= pend_q.slot_index;
						out_q.status     <= pend_q.status;
						out_q.last       <= 1'b1;
						pend_valid_q     <= 1'b0;
						state_q          <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### design/ptss_checker.sv
// ----------------------------------------------------------------------------
// ptss_checker - port-level checks for the periodic task slot scheduler
// Watches the handshakes and result codes seen on the top level's ports.
// ----------------------------------------------------------------------------
module ptss_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input ptss_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input ptss_pkg::out_item_t out_data
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	// Busy after a schedule or tick transfer
	a_busy_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready &&
		(in_data.kind == ptss_pkg::KIND_SCHED || in_data.kind == ptss_pkg::KIND_TICK)
		|=> !in_ready)
		else $error("input taken again during a slot walk");

	// Schedule answers are single results
	a_sched_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ptss_pkg::STAT_SCHEDULED ||
		              out_data.status == ptss_pkg::STAT_FULL)
		|-> out_data.last)
		else $error("schedule result without last");

	// A full table reports slot zero
	a_full_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ptss_pkg::STAT_FULL |-> out_data.slot_index == 5'd0)
		else $error("full result with nonzero slot");

endmodule

bind periodic_task_slot_scheduler ptss_checker u_ptss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
